>>> design/rfla_pkg.sv
package rfla_pkg;

  localparam int REG_COUNT_DEF = 256;
  localparam int MAP_N         = 256;
  localparam int IDX_W         = 8;
  localparam int LIM_W         = 9;
  localparam int CHUNK_W       = 64;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 32;
  localparam logic [LIM_W-1:0] ACTIVE_RST = 9'd256;

  typedef enum logic [2:0] {
    MODE_ALLOC   = 3'd0,
    MODE_NAMED   = 3'd1,
    MODE_FREE    = 3'd2,
    MODE_RESERVE = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_TOP  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

endpackage

>>> design/register_free_list_allocator.sv
// Register number allocator with taken and reserved bitmaps, a LIFO stack of
// freed numbers and an upward scan that never wraps. One transaction is taken
// at a time: in_tready is high only while the sequencer is idle, though a
// finished result may still wait on the output register. Free, named
// allocate, reserve, clear all and query pass through the execute and
// response states before out_tvalid rises. Allocate served from the stack top
// goes through the execute, top and response states. When it scans, the
// 64-bit chunk search unit checks one 64-register chunk at a time, at most 4,
// until it finds a free register or the scan pointer reaches the limit. A
// result that finds the output register still full holds the sequencer until
// out_tready, and in_tready returns in the same cycle that out_tvalid rises.
// active_registers (cfg_wr_data) may only change while the block is idle.
module register_free_list_allocator #(
  parameter int REG_COUNT = rfla_pkg::REG_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rfla_pkg::LIM_W-1:0]         cfg_wr_data,   // active_registers
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rfla_pkg::IN_TDATA_W-1:0]    in_tdata,      // mode[2:0], reg_index[10:3]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[0], granted_reg[8:1], is_taken[9], taken_count[18:10],
  // high_mark[26:19], stack_overflow[27]
  output logic [rfla_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import rfla_pkg::*;

  localparam int SA_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int SD_W    = $clog2(REG_COUNT + 1);
  localparam int LIM_CAP = (REG_COUNT < MAP_N) ? REG_COUNT : MAP_N;
  localparam int OFF_W   = $clog2(CHUNK_W);
  localparam int CH_W    = IDX_W - OFF_W;

  state_t               state_r, state_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 status_r, status_nxt;
  logic [IDX_W-1:0]     granted_r, granted_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAP_N-1:0]     taken_r, taken_nxt;
  logic [MAP_N-1:0]     resv_r, resv_nxt;
  logic [SD_W-1:0]      depth_r, depth_nxt;
  logic [LIM_W-1:0]     scan_start_r, scan_start_nxt;
  logic [LIM_W-1:0]     scan_ptr_r, scan_ptr_nxt;
  logic [IDX_W-1:0]     peak_r, peak_nxt;
  logic [LIM_W-1:0]     live_r, live_nxt;
  logic [LIM_W-1:0]     active_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [IDX_W-1:0]     stk_mem [REG_COUNT];
  logic [IDX_W-1:0]     rd_data_r;
  logic                 stk_rd, stk_we;
  logic [SD_W-1:0]      depth_m1;

  logic [LIM_W-1:0]     lim;
  logic                 in_range;
  logic                 grant_en;
  logic [IDX_W-1:0]     grant_k;
  logic                 e_in;

  logic [MAP_N-1:0]     free_vec;
  logic [CH_W-1:0]      scan_chunk;
  logic [OFF_W-1:0]     scan_off;
  logic [CHUNK_W-1:0]   scan_word;
  logic [CHUNK_W-1:0]   scan_cand;
  logic                 scan_hit;
  logic [OFF_W-1:0]     scan_sel;
  logic [IDX_W-1:0]     scan_k;
  logic [LIM_W-1:0]     scan_next;

  always_comb begin
    if (active_r > LIM_W'(LIM_CAP)) begin
      lim = LIM_W'(LIM_CAP);
    end else begin
      lim = active_r;
    end
  end

  assign in_range  = {1'b0, idx_r} < lim;
  assign e_in      = {1'b0, rd_data_r} < lim;
  assign depth_m1  = depth_r - SD_W'(1);
  assign in_tready = (state_r == ST_IDLE);

  // chunked lowest-free search
  assign free_vec   = ~taken_r & ~resv_r;
  assign scan_chunk = scan_ptr_r[IDX_W-1:OFF_W];
  assign scan_off   = scan_ptr_r[OFF_W-1:0];
  assign scan_word  = free_vec[scan_chunk*CHUNK_W +: CHUNK_W];
  assign scan_hit   = |scan_cand;
  assign scan_k     = {scan_chunk, scan_sel};
  assign scan_next  = {({1'b0, scan_chunk} + (CH_W+1)'(1)), {OFF_W{1'b0}}};

  always_comb begin
    for (int i = 0; i < CHUNK_W; i++) begin
      scan_cand[i] = scan_word[i] && (OFF_W'(i) >= scan_off) &&
                     ({1'b0, scan_chunk, OFF_W'(i)} < lim);
    end
  end

  always_comb begin
    scan_sel = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (scan_cand[i]) scan_sel = OFF_W'(i);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    ovf_nxt        = ovf_r;
    taken_nxt      = taken_r;
    resv_nxt       = resv_r;
    depth_nxt      = depth_r;
    scan_start_nxt = scan_start_r;
    scan_ptr_nxt   = scan_ptr_r;
    peak_nxt       = peak_r;
    live_nxt       = live_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    stk_rd         = 1'b0;
    stk_we         = 1'b0;
    grant_en       = 1'b0;
    grant_k        = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt    = in_tdata[2:0];
          idx_nxt     = in_tdata[10:3];
          status_nxt  = 1'b1;
          granted_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        unique case (mode_r)
          MODE_ALLOC: begin
            scan_ptr_nxt = scan_start_r;
            if (depth_r != '0) begin
              stk_rd    = 1'b1;
              state_nxt = ST_TOP;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          MODE_NAMED: begin
            if (in_range && !taken_r[idx_r] && !resv_r[idx_r]) begin
              grant_en   = 1'b1;
              grant_k    = idx_r;
              status_nxt = 1'b0;
            end
          end
          MODE_FREE: begin
            if (in_range && taken_r[idx_r] && !resv_r[idx_r]) begin
              taken_nxt[idx_r] = 1'b0;
              if (live_r != '0) live_nxt = live_r - LIM_W'(1);
              if (depth_r < SD_W'(REG_COUNT)) begin
                stk_we    = 1'b1;
                depth_nxt = depth_r + SD_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              status_nxt = 1'b0;
            end
          end
          MODE_RESERVE: begin
            if (in_range) begin
              resv_nxt[idx_r] = 1'b1;
              if (taken_r[idx_r]) begin
                taken_nxt[idx_r] = 1'b0;
                if (live_r != '0) live_nxt = live_r - LIM_W'(1);
              end
              status_nxt = 1'b0;
            end
          end
          MODE_CLEAR: begin
            taken_nxt      = '0;
            resv_nxt       = '0;
            depth_nxt      = '0;
            scan_start_nxt = '0;
            peak_nxt       = '0;
            live_nxt       = '0;
            status_nxt     = 1'b0;
          end
          MODE_QUERY: begin
            status_nxt = !in_range;
          end
          default: begin
          end
        endcase
      end
      ST_TOP: begin
        if (e_in && resv_r[rd_data_r]) begin
          state_nxt = ST_SCAN;
        end else if (e_in && !taken_r[rd_data_r]) begin
          depth_nxt   = depth_m1;
          grant_en    = 1'b1;
          grant_k     = rd_data_r;
          granted_nxt = rd_data_r;
          status_nxt  = 1'b0;
          state_nxt   = ST_RESP;
        end else begin
          depth_nxt = depth_m1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_ptr_r >= lim) begin
          state_nxt = ST_RESP;
        end else if (scan_hit) begin
          grant_en       = 1'b1;
          grant_k        = scan_k;
          granted_nxt    = scan_k;
          scan_start_nxt = {1'b0, scan_k} + LIM_W'(1);
          status_nxt     = 1'b0;
          state_nxt      = ST_RESP;
        end else begin
          scan_ptr_nxt = scan_next;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, ovf_r, peak_r, live_r,
                           in_range && taken_r[idx_r], granted_r, status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (grant_en) begin
      taken_nxt[grant_k] = 1'b1;
      live_nxt           = live_r + LIM_W'(1);
      if (grant_k > peak_r) peak_nxt = grant_k;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[depth_r[SA_W-1:0]] <= idx_r;
    if (stk_rd) rd_data_r <= stk_mem[depth_m1[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      taken_r      <= '0;
      resv_r       <= '0;
      depth_r      <= '0;
      scan_start_r <= '0;
      peak_r       <= '0;
      live_r       <= '0;
      active_r     <= ACTIVE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      taken_r      <= taken_nxt;
      resv_r       <= resv_nxt;
      depth_r      <= depth_nxt;
      scan_start_r <= scan_start_nxt;
      peak_r       <= peak_nxt;
      live_r       <= live_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) active_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    ovf_r      <= ovf_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_EXEC)
    else $error("accepted transaction did not start execution");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SD_W'(REG_COUNT))
    else $error("free stack depth beyond capacity");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[8:1] == '0)
    else $error("failed transaction carries a granted register");

  a_scan_grant: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && scan_ptr_r < lim && scan_hit |=> taken_r[$past(scan_k)])
    else $error("scan hit did not mark the register taken");

  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESP && (!out_valid_r || out_tready) |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not loaded into output register");

endmodule

>>> tb/tb_register_free_list_allocator.sv
module tb_register_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import rfla_pkg::*;

  localparam logic [2:0] MODE_UNUSED6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED7 = 3'd7;
  localparam int MAP_DEPTH   = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 12;

  typedef struct packed {
    logic       overflow;
    logic [7:0] high_mark;
    logic [8:0] taken_count;
    logic       is_taken;
    logic [7:0] granted_reg;
    logic       status;
  } alloc_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [LIM_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // allocator state as the block should hold it
  bit   taken_map    [MAP_DEPTH];
  bit   reserved_map [MAP_DEPTH];
  int   free_stack   [MAP_DEPTH];
  int   stack_depth;
  int   scan_ptr;
  int   peak_reg;
  int   live_count;
  int   active_regs;

  alloc_result_t predicted_replies[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_cycles = 0;
  int cycle_cnt = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_ovf = 0;
  int n_fail = 0;

  register_free_list_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL register_free_list_allocator");
      $finish;
    end
  end

  function automatic int reg_limit();
    return (active_regs > MAP_DEPTH) ? MAP_DEPTH : active_regs;
  endfunction

  function automatic void clear_allocator();
    for (int i = 0; i < MAP_DEPTH; i++) begin
      taken_map[i] = 1'b0;
      reserved_map[i] = 1'b0;
      free_stack[i] = 0;
    end
    stack_depth = 0;
    scan_ptr = 0;
    peak_reg = 0;
    live_count = 0;
  endfunction

  function automatic void grant_reg(int r);
    taken_map[r] = 1'b1;
    live_count++;
    if (r > peak_reg) peak_reg = r;
  endfunction

  function automatic alloc_result_t predict_alloc(logic [2:0] mode, logic [7:0] idx);
    alloc_result_t res;
    int  lim;
    int  e;
    int  r;
    bit  in_range;
    bit  done;
    res = '0;
    res.status = 1'b1;
    lim = reg_limit();
    r = int'(idx);
    in_range = r < lim;
    done = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (stack_depth > 0) begin
          e = free_stack[stack_depth-1];
          if (!(e < lim && reserved_map[e])) begin
            stack_depth--;
            if (e < lim && !taken_map[e]) begin
              grant_reg(e);
              res.granted_reg = 8'(e);
              done = 1'b1;
            end
          end
        end
        if (!done) begin
          for (int k = scan_ptr; k < lim; k++) begin
            if (!taken_map[k] && !reserved_map[k]) begin
              grant_reg(k);
              res.granted_reg = 8'(k);
              scan_ptr = k + 1;
              done = 1'b1;
              break;
            end
          end
        end
        res.status = !done;
      end
      MODE_NAMED: begin
        if (in_range && !taken_map[r] && !reserved_map[r]) begin
          grant_reg(r);
          res.status = 1'b0;
        end
      end
      MODE_FREE: begin
        if (in_range && taken_map[r] && !reserved_map[r]) begin
          taken_map[r] = 1'b0;
          if (live_count > 0) live_count--;
          if (stack_depth < MAP_DEPTH) begin
            free_stack[stack_depth] = r;
            stack_depth++;
          end else begin
            res.overflow = 1'b1;
          end
          res.status = 1'b0;
        end
      end
      MODE_RESERVE: begin
        if (in_range) begin
          reserved_map[r] = 1'b1;
          if (taken_map[r]) begin
            taken_map[r] = 1'b0;
            if (live_count > 0) live_count--;
          end
          res.status = 1'b0;
        end
      end
      MODE_CLEAR: begin
        clear_allocator();
        res.status = 1'b0;
      end
      MODE_QUERY: res.status = !in_range;
      default: ;
    endcase
    res.is_taken = in_range && taken_map[r];
    res.taken_count = 9'(live_count);
    res.high_mark = 8'(peak_reg);
    return res;
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] pick_taken();
    int lim;
    int s;
    lim = reg_limit();
    s = $urandom_range(lim - 1);
    for (int k = 0; k < lim; k++) begin
      if (taken_map[(s + k) % lim]) return 8'((s + k) % lim);
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    errors++;
    $display("mismatch in %s at reply %0d: expected %0d, got %0d",
             field, n_checked, exp_v, got_v);
  endtask

  // checker: compare each reply against the oldest prediction
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[27:0];
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected reply", 0, out_tdata);
      end else begin
        want = predicted_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.granted_reg !== want.granted_reg)
          report_mismatch("granted_reg", 32'(want.granted_reg), 32'(got.granted_reg));
        if (got.is_taken !== want.is_taken)
          report_mismatch("is_taken", 32'(want.is_taken), 32'(got.is_taken));
        if (got.taken_count !== want.taken_count)
          report_mismatch("taken_count", 32'(want.taken_count), 32'(got.taken_count));
        if (got.high_mark !== want.high_mark)
          report_mismatch("high_mark", 32'(want.high_mark), 32'(got.high_mark));
        if (got.overflow !== want.overflow)
          report_mismatch("stack_overflow", 32'(want.overflow), 32'(got.overflow));
      end
      n_checked++;
    end
  end

  // result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        n = pick_gap(rx_idle);
        if (n == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_request(logic [2:0] mode, logic [7:0] idx);
    alloc_result_t want;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-11){1'b0}}, idx, mode};
    do @(posedge clk); while (!in_tready);
    want = predict_alloc(mode, idx);
    predicted_replies.insert(predicted_replies.size(), want);
    n_sent++;
    if (want.status) n_fail++;
    if (want.overflow) n_ovf++;
    gap = pick_gap(tx_idle);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_replies_done();
    in_tvalid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(int value);
    wait_replies_done();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LIM_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_regs = value;
    n_cfg++;
  endtask

  task automatic test_directed_cases();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_FREE, 8'd1);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_FREE, 8'd1);
    // reserved entry on top of the free stack stays there
    send_request(MODE_RESERVE, 8'd1);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_NAMED, 8'd1);
    send_request(MODE_FREE, 8'd1);
    send_request(MODE_NAMED, 8'd2);
    send_request(MODE_FREE, 8'd200);
    // stale top: taken again before the next allocate pops it
    send_request(MODE_FREE, 8'd0);
    send_request(MODE_NAMED, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_NAMED, 8'd255);
    send_request(MODE_QUERY, 8'd255);
    send_request(MODE_QUERY, 8'd0);
    send_request(MODE_UNUSED6, 8'd3);
    send_request(MODE_UNUSED7, 8'd170);
    send_request(MODE_RESERVE, 8'd255);
    send_request(MODE_CLEAR, 8'd85);
    send_request(MODE_QUERY, 8'd0);
  endtask

  task automatic test_limit_edges();
    set_limit(4);
    send_request(MODE_CLEAR, 8'd0);
    repeat (5) send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_NAMED, 8'd4);
    send_request(MODE_FREE, 8'd4);
    send_request(MODE_RESERVE, 8'd255);
    send_request(MODE_QUERY, 8'd4);
    send_request(MODE_QUERY, 8'd3);
    set_limit(1);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_CLEAR, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_FREE, 8'd0);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_QUERY, 8'd1);
    // shrink the limit under taken registers and a stacked entry
    set_limit(256);
    send_request(MODE_CLEAR, 8'd0);
    send_request(MODE_NAMED, 8'd200);
    send_request(MODE_NAMED, 8'd10);
    send_request(MODE_FREE, 8'd200);
    send_request(MODE_NAMED, 8'd150);
    set_limit(100);
    send_request(MODE_QUERY, 8'd150);
    send_request(MODE_FREE, 8'd150);
    send_request(MODE_ALLOC, 8'd0);
    send_request(MODE_FREE, 8'd10);
    send_request(MODE_ALLOC, 8'd0);
  endtask

  task automatic test_stack_overflow();
    int order [MAP_DEPTH];
    int j;
    int t;
    int r;
    set_limit(256);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_request(MODE_CLEAR, 8'd0);
    for (int i = 0; i < MAP_DEPTH; i++) begin
      send_request(MODE_NAMED, 8'(i));
      order[i] = i;
    end
    for (int i = MAP_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < MAP_DEPTH; i++) send_request(MODE_FREE, 8'(order[i]));
    r = $urandom_range(255);
    send_request(MODE_NAMED, 8'(r));
    send_request(MODE_FREE, 8'(r));
    repeat (4) send_request(MODE_ALLOC, 8'd0);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_cycles = 250;
    repeat (30) begin
      if ($urandom_range(1)) send_request(MODE_ALLOC, 8'd0);
      else send_request(MODE_FREE, pick_taken());
    end
    wait_replies_done();
  endtask

  task automatic test_random_traffic(int count, int limit, bit tx_on, bit rx_on);
    int r;
    int lim;
    logic [2:0] mode;
    logic [7:0] idx;
    set_limit(limit);
    tx_idle = tx_on;
    rx_idle = rx_on;
    repeat (count) begin
      lim = reg_limit();
      r = $urandom_range(99);
      if (r < 34) mode = MODE_ALLOC;
      else if (r < 58) mode = MODE_FREE;
      else if (r < 72) mode = MODE_NAMED;
      else if (r < 84) mode = MODE_QUERY;
      else if (r < 88) mode = MODE_RESERVE;
      else if (r < 89) mode = MODE_CLEAR;
      else if (r < 94) mode = $urandom_range(1) ? MODE_UNUSED6 : MODE_UNUSED7;
      else mode = 3'($urandom_range(7));
      if (mode == MODE_FREE && $urandom_range(99) < 75) idx = pick_taken();
      else if ($urandom_range(99) < 85) idx = 8'($urandom_range(lim - 1));
      else idx = 8'($urandom_range(255));
      send_request(mode, idx);
    end
  endtask

  initial begin
    active_regs = 256;
    clear_allocator();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_limit_edges();
    test_stack_overflow();
    test_backpressure();
    test_random_traffic(220, 256, 1'b1, 1'b1);
    test_random_traffic(220, 255, 1'b0, 1'b0);
    test_random_traffic(200, 17, 1'b1, 1'b1);
    test_random_traffic(200, 200, 1'b1, 1'b0);
    test_random_traffic(200, 64, 1'b0, 1'b1);
    test_random_traffic(80, 1, 1'b1, 1'b1);
    test_random_traffic(200, 256, 1'b1, 1'b1);
    wait_replies_done();
    $display("Sent %0d requests, checked %0d replies across %0d limit writes",
             n_sent, n_checked, n_cfg);
    $display("Replies with failure status: %0d, dropped stack pushes: %0d", n_fail, n_ovf);
    if (errors == 0) begin
      $display("PASS register_free_list_allocator");
    end else begin
      $display("FAIL register_free_list_allocator");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rfla_pkg.sv
design/register_free_list_allocator.sv
tb/tb_register_free_list_allocator.sv
